// ===== src/rmq_pkg.sv =====
// Shared types, constants and datapath step functions for the matrix-to-quaternion core.
package rmq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int FRONT_STGS = 2;
  localparam int ROOT_STEPS = 16;
  localparam int NORM_STEPS = 17;
  localparam int DIV_STEPS  = 15;
  localparam int LAT        = FRONT_STGS + ROOT_STEPS + 1 + 1 + NORM_STEPS + 1 + DIV_STEPS;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_t;

  // Clamped diagonal sums and the negative-sign flag of each lane (w, x, y, z).
  typedef struct packed {
    logic [3:0][16:0] s;
    logic [3:0]       neg;
  } front_t;

  // One digit-recurrence square root lane: partial remainder and root.
  typedef struct packed {
    logic [20:0] rem;
    logic [17:0] root;
  } sq_t;

  typedef struct packed {
    sq_t  [3:0]       ln;
    logic [3:0][31:0] rad;
    logic [3:0]       neg;
  } root_t;

  typedef struct packed {
    logic [3:0][15:0] t;
    logic [3:0][31:0] p;
    logic [3:0]       neg;
  } sqr_t;

  typedef struct packed {
    logic [3:0][15:0] t;
    logic [33:0]      sum;
    logic [3:0]       neg;
  } sum_t;

  typedef struct packed {
    sq_t              acc;
    logic [33:0]      rad;
    logic [3:0][15:0] t;
    logic [3:0]       neg;
  } norm_t;

  typedef struct packed {
    logic [3:0][30:0] num;
    logic [16:0]      n;
    logic [3:0]       neg;
  } num_t;

  // Restoring divide: remainder, remaining dividend bits shifted out as quotient shifts in.
  typedef struct packed {
    logic [3:0][16:0] rem;
    logic [3:0][14:0] lo;
    logic [16:0]      n;
    logic [3:0]       neg;
  } div_t;

  function automatic sq_t sqrt_step(sq_t s, logic [1:0] pair);
    logic [20:0] trial;
    logic [20:0] cand;
    sq_t         r;
    trial = {s.rem[18:0], pair};
    cand  = {1'b0, s.root, 2'b01};
    if (trial >= cand) begin
      r.rem  = trial - cand;
      r.root = {s.root[16:0], 1'b1};
    end else begin
      r.rem  = trial;
      r.root = {s.root[16:0], 1'b0};
    end
    return r;
  endfunction

  function automatic root_t root_seed(front_t f);
    root_t r;
    for (int k = 0; k < 4; k++) begin
      r.ln[k]  = '0;
      r.rad[k] = {1'b0, f.s[k], 14'b0};
    end
    r.neg = f.neg;
    return r;
  endfunction

  function automatic root_t root_step(root_t a);
    root_t r;
    r = a;
    for (int k = 0; k < 4; k++) begin
      r.ln[k]  = sqrt_step(a.ln[k], a.rad[k][31:30]);
      r.rad[k] = {a.rad[k][29:0], 2'b00};
    end
    return r;
  endfunction

  function automatic sqr_t square_lanes(root_t a);
    sqr_t r;
    for (int k = 0; k < 4; k++) begin
      r.t[k] = a.ln[k].root[15:0];
      r.p[k] = {16'b0, r.t[k]} * {16'b0, r.t[k]};
    end
    r.neg = a.neg;
    return r;
  endfunction

  function automatic sum_t sum_lanes(sqr_t a);
    sum_t r;
    r.t   = a.t;
    r.sum = 34'(a.p[0]) + 34'(a.p[1]) + 34'(a.p[2]) + 34'(a.p[3]);
    r.neg = a.neg;
    return r;
  endfunction

  function automatic norm_t norm_seed(sum_t a);
    norm_t r;
    r.acc = '0;
    r.rad = a.sum;
    r.t   = a.t;
    r.neg = a.neg;
    return r;
  endfunction

  function automatic norm_t norm_step(norm_t a);
    norm_t r;
    r     = a;
    r.acc = sqrt_step(a.acc, a.rad[33:32]);
    r.rad = {a.rad[31:0], 2'b00};
    return r;
  endfunction

  // Numerator with half the divisor added, for round-half-up.
  function automatic num_t num_lanes(norm_t a);
    num_t r;
    r.n = a.acc.root[16:0];
    for (int k = 0; k < 4; k++) begin
      r.num[k] = 31'({a.t[k], 14'b0}) + 31'(r.n[16:1]);
    end
    r.neg = a.neg;
    return r;
  endfunction

  function automatic div_t div_seed(num_t a);
    div_t r;
    for (int k = 0; k < 4; k++) begin
      r.rem[k] = {1'b0, a.num[k][30:15]};
      r.lo[k]  = a.num[k][14:0];
    end
    r.n   = a.n;
    r.neg = a.neg;
    return r;
  endfunction

  function automatic div_t div_step(div_t a);
    div_t        r;
    logic [17:0] trial;
    logic        qb;
    r = a;
    for (int k = 0; k < 4; k++) begin
      trial = {a.rem[k], a.lo[k][14]};
      qb    = (trial >= {1'b0, a.n});
      if (qb) begin
        r.rem[k] = 17'(trial - {1'b0, a.n});
      end else begin
        r.rem[k] = trial[16:0];
      end
      r.lo[k] = {a.lo[k][13:0], qb};
    end
    return r;
  endfunction

  function automatic out_t make_out(div_t a);
    out_t             r;
    logic [3:0][15:0] v;
    logic [15:0]      mag;
    for (int k = 0; k < 4; k++) begin
      mag = {1'b0, a.lo[k]};
      if (mag > 16'(ONE)) begin
        mag = 16'(ONE);
      end
      v[k] = a.neg[k] ? (~mag + 16'd1) : mag;
    end
    r.quat_w = $signed(v[0]);
    r.quat_x = $signed(v[1]);
    r.quat_y = $signed(v[2]);
    r.quat_z = $signed(v[3]);
    return r;
  endfunction

endpackage

// ===== src/rotation_matrix_to_quaternion_core.sv =====
// Top level: pipelined rotation-matrix to unit-quaternion converter with output skid stage.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   rmq_pkg::in_t  (m00..m22, Q1.14)
//  out_     output     out_valid/out_stall rmq_pkg::out_t (quat_x..quat_w, Q1.14)
//
// Takes one matrix per cycle while in_stall is low; each result reaches out_valid
// through 54 register stages: 2 front stages, 16 candidate root steps, square, sum,
// 17 norm root steps, numerator, 15 divide steps and the output register.
// rst_n is synchronous, active low, and clears only the valid bits.
// The whole pipeline advances on one enable; a result that meets a stalled output
// register parks in the skid register, and the pipeline holds while that is full.
module rotation_matrix_to_quaternion_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rmq_pkg::out_t out_data
);
  import rmq_pkg::*;

  logic           en;
  logic           acc;
  logic           take;
  logic           push;
  logic [LAT-1:0] v_r, v_nxt;

  front_t fr;
  root_t  rt_r [ROOT_STEPS];
  sqr_t   sq_r;
  sum_t   sm_r;
  norm_t  nm_r [NORM_STEPS];
  num_t   nu_r;
  div_t   dv_r [DIV_STEPS];
  out_t   res;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t out_data_r, out_data_nxt;
  out_t skid_r, skid_nxt;

  // Freeze every stage while a result sits in the skid register.
  assign en       = ~skid_valid_r;
  assign in_stall = skid_valid_r;
  assign acc      = in_valid & en;

  rmq_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .fr_data (fr)
  );

  // Candidate roots: one result bit per stage, four lanes side by side.
  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    root_t src;
    if (j == 0) begin : g_seed
      assign src = root_seed(fr);
    end else begin : g_chain
      assign src = rt_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[j] <= root_step(src);
      end
    end
  end

  // Square each root, then add the four squares.
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= square_lanes(rt_r[ROOT_STEPS-1]);
      sm_r <= sum_lanes(sq_r);
    end
  end

  // Norm: root of the sum of squares, one bit per stage.
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    norm_t src;
    if (j == 0) begin : g_seed
      assign src = norm_seed(sm_r);
    end else begin : g_chain
      assign src = nm_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nm_r[j] <= norm_step(src);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nu_r <= num_lanes(nm_r[NORM_STEPS-1]);
    end
  end

  // Divide each lane by the norm, one quotient bit per stage.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    div_t src;
    if (j == 0) begin : g_seed
      assign src = div_seed(nu_r);
    end else begin : g_chain
      assign src = dv_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j] <= div_step(src);
      end
    end
  end

  // Clamp, apply sign and reorder lanes into x, y, z, w.
  assign res = make_out(dv_r[DIV_STEPS-1]);

  assign v_nxt = en ? {v_r[LAT-2:0], acc} : v_r;
  assign take  = out_valid_r & ~out_stall;
  assign push  = en & v_r[LAT-1];

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // Drain the skid into the output register once the held result is taken.
      if (take) begin
        out_data_nxt   = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      v_r          <= v_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_r     <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> ($past(out_stall) && $past(out_valid_r)))
    else $error("skid filled without a stalled output");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |=> $stable(v_r))
    else $error("pipeline advanced while skid was full");
`endif

endmodule

// ===== src/rmq_front.sv =====
// Front end: diagonal sums, clamp, dominant lane pick and sign selection (two stages).
module rmq_front (
  input  logic            clk,
  input  logic            en,
  input  rmq_pkg::in_t    in_data,
  output rmq_pkg::front_t fr_data
);
  import rmq_pkg::*;

  typedef enum logic [1:0] {
    LANE_W = 2'd0,
    LANE_X = 2'd1,
    LANE_Y = 2'd2,
    LANE_Z = 2'd3
  } lane_t;

  typedef struct packed {
    logic [3:0][16:0] s;
    logic [5:0]       nf;
  } fa_t;

  localparam logic signed [17:0] ONE_S = 18'(ONE);

  fa_t    fa_r, fa_nxt;
  front_t fb_r, fb_nxt;

  logic signed [17:0] e00, e11, e22;
  logic signed [17:0] s_raw [4];
  logic signed [16:0] dv    [6];
  lane_t              win;
  logic [16:0]        best;

  always_comb begin
    e00 = 18'(in_data.m00);
    e11 = 18'(in_data.m11);
    e22 = 18'(in_data.m22);
    s_raw[0] = ONE_S + e00 + e11 + e22;
    s_raw[1] = ONE_S + e00 - e11 - e22;
    s_raw[2] = ONE_S - e00 + e11 - e22;
    s_raw[3] = ONE_S - e00 - e11 + e22;
    dv[0] = 17'(in_data.m21) - 17'(in_data.m12);
    dv[1] = 17'(in_data.m02) - 17'(in_data.m20);
    dv[2] = 17'(in_data.m10) - 17'(in_data.m01);
    dv[3] = 17'(in_data.m10) + 17'(in_data.m01);
    dv[4] = 17'(in_data.m02) + 17'(in_data.m20);
    dv[5] = 17'(in_data.m21) + 17'(in_data.m12);
    for (int k = 0; k < 4; k++) begin
      fa_nxt.s[k] = s_raw[k][17] ? '0 : s_raw[k][16:0];
    end
    for (int k = 0; k < 6; k++) begin
      fa_nxt.nf[k] = dv[k][16];
    end
  end

  // Strictly-greater compare keeps ties on the earlier lane.
  always_comb begin
    win  = LANE_W;
    best = fa_r.s[0];
    if (fa_r.s[1] > best) begin
      win  = LANE_X;
      best = fa_r.s[1];
    end
    if (fa_r.s[2] > best) begin
      win  = LANE_Y;
      best = fa_r.s[2];
    end
    if (fa_r.s[3] > best) begin
      win = LANE_Z;
    end
    fb_nxt.s = fa_r.s;
    case (win)
      LANE_W: fb_nxt.neg = {fa_r.nf[2], fa_r.nf[1], fa_r.nf[0], 1'b0};
      LANE_X: fb_nxt.neg = {fa_r.nf[4], fa_r.nf[3], 1'b0, fa_r.nf[0]};
      LANE_Y: fb_nxt.neg = {fa_r.nf[5], 1'b0, fa_r.nf[3], fa_r.nf[1]};
      LANE_Z: fb_nxt.neg = {1'b0, fa_r.nf[5], fa_r.nf[4], fa_r.nf[2]};
      default: fb_nxt.neg = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r <= fa_nxt;
      fb_r <= fb_nxt;
    end
  end

  assign fr_data = fb_r;

endmodule
